// File: sv/vn_pkg.sv
// Shared constants for the vector normalizer.
package vn_pkg;
    localparam int VN_QW        = 16;    // result width, Q1.15
    localparam int VN_FRAC      = 8;     // fractional bits of the length
    localparam int VN_SHIFT     = 23;    // dividend scale: 15 + VN_FRAC
    localparam int VN_UNIT_MAX  = 32767;
endpackage

// File: sv/vn_if.sv
// Valid/ready channel interfaces for input vectors and unit vectors.
interface vn_in_if #(parameter int COMPONENT_WIDTH = 16);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] x_in;
    logic signed [COMPONENT_WIDTH-1:0] y_in;
    logic signed [COMPONENT_WIDTH-1:0] z_in;
    modport source (output valid, x_in, y_in, z_in, input ready);
    modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface vn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_unit;
    logic signed [15:0] y_unit;
    logic signed [15:0] z_unit;
    logic               zero_vector;
    modport source (output valid, x_unit, y_unit, z_unit, zero_vector, input ready);
    modport sink   (input valid, x_unit, y_unit, z_unit, zero_vector, output ready);
endinterface

// File: sv/vn_sq.sv
// Magnitude split, squaring and sum of squares (three stages).
module vn_sq #(
    parameter int W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [3*W-1:0]    i_comp,
    output logic              o_valid,
    output logic [3*W-1:0]    o_mag,
    output logic [2:0]        o_neg,
    output logic [2*W-1:0]    o_sum
);
    logic [2:0]     r_v;
    logic [3*W-1:0] r_mag1, r_mag2, r_mag3;
    logic [2:0]     r_neg1, r_neg2, r_neg3;
    logic [2*W-1:0] r_sq [0:2];
    logic [2*W-1:0] r_sum;
    logic [3*W-1:0] n_mag;
    logic [2:0]     n_neg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_neg[j]           = i_comp[j*W + W-1];
            n_mag[j*W +: W]    = n_neg[j] ? (~i_comp[j*W +: W]) + W'(1) : i_comp[j*W +: W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag1 <= n_mag;
            r_neg1 <= n_neg;
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= r_mag1[j*W +: W] * r_mag1[j*W +: W];
            end
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
            r_sum  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_mag3 <= r_mag2;
            r_neg3 <= r_neg2;
        end
    end

    assign o_valid = r_v[2];
    assign o_mag   = r_mag3;
    assign o_neg   = r_neg3;
    assign o_sum   = r_sum;
endmodule

// File: sv/vn_sqrt.sv
// Pipelined integer square root of sum << 16, one result bit per stage.
module vn_sqrt #(
    parameter int W  = 16,
    parameter int SW = 52
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*W-1:0]    i_sum,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [W+7:0]      o_root,
    output logic [SW-1:0]     o_side
);
    import vn_pkg::*;
    localparam int N  = W + VN_FRAC;   // root bits = stages
    localparam int RW = W + 10;        // partial remainder width

    logic [2*N-1:0] a_rad  [0:N-1];
    logic [RW-1:0]  a_rem  [0:N-1];
    logic [N-1:0]   a_root [0:N-1];
    logic [SW-1:0]  a_side [0:N-1];
    logic           a_v    [0:N-1];

    logic [2*N-1:0] r_rad  [1:N];
    logic [RW-1:0]  r_rem  [1:N];
    logic [N-1:0]   r_root [1:N];
    logic [SW-1:0]  r_side [1:N];
    logic           r_v    [1:N];

    assign a_rad[0]  = {i_sum, 16'b0};
    assign a_rem[0]  = '0;
    assign a_root[0] = '0;
    assign a_side[0] = i_side;
    assign a_v[0]    = i_valid;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [RW-1:0] n_cur, n_trial;
        logic          n_ge;
        if (i > 0) begin : g_link
            assign a_rad[i]  = r_rad[i];
            assign a_rem[i]  = r_rem[i];
            assign a_root[i] = r_root[i];
            assign a_side[i] = r_side[i];
            assign a_v[i]    = r_v[i];
        end
        assign n_cur   = {a_rem[i][RW-3:0], a_rad[i][2*N-1 -: 2]};
        assign n_trial = {a_root[i], 2'b01};
        assign n_ge    = n_cur >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= a_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[i+1]  <= a_rad[i] << 2;
                r_rem[i+1]  <= n_ge ? n_cur - n_trial : n_cur;
                r_root[i+1] <= {a_root[i][N-2:0], n_ge};
                r_side[i+1] <= a_side[i];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_root[N];
    assign o_side  = r_side[N];
endmodule

// File: sv/vn_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module vn_div #(
    parameter int W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W+7:0]      i_len,
    input  logic [3*W-1:0]    i_mag,
    input  logic [3:0]        i_flags,   // {zero, neg[2:0]}
    output logic              o_valid,
    output logic [47:0]       o_quo,
    output logic [3:0]        o_flags
);
    import vn_pkg::*;
    localparam int DW = W + VN_SHIFT;
    localparam int NS = VN_QW;

    logic [DW-1:0]    a_rem [0:NS-1][0:2];
    logic [NS-1:0]    a_q   [0:NS-1][0:2];
    logic [W+7:0]     a_len [0:NS-1];
    logic [3:0]       a_fl  [0:NS-1];
    logic             a_v   [0:NS-1];

    logic [DW-1:0]    r_rem [1:NS][0:2];
    logic [NS-1:0]    r_q   [1:NS][0:2];
    logic [W+7:0]     r_len [1:NS];
    logic [3:0]       r_fl  [1:NS];
    logic             r_v   [1:NS];

    for (genvar j = 0; j < 3; j++) begin : g_init
        assign a_rem[0][j] = DW'(i_mag[j*W +: W]) << VN_SHIFT;
        assign a_q[0][j]   = '0;
    end
    assign a_len[0] = i_len;
    assign a_fl[0]  = i_flags;
    assign a_v[0]   = i_valid;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [DW-1:0] n_dsh;
        if (k > 0) begin : g_link
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign a_rem[k][j] = r_rem[k][j];
                assign a_q[k][j]   = r_q[k][j];
            end
            assign a_len[k] = r_len[k];
            assign a_fl[k]  = r_fl[k];
            assign a_v[k]   = r_v[k];
        end
        assign n_dsh = DW'(a_len[k]) << (NS - 1 - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= a_v[k];
            end
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane_op
            logic n_ge;
            assign n_ge = a_rem[k][j] >= n_dsh;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1][j] <= n_ge ? a_rem[k][j] - n_dsh : a_rem[k][j];
                    r_q[k+1][j]   <= {a_q[k][j][NS-2:0], n_ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[k+1] <= a_len[k];
                r_fl[k+1]  <= a_fl[k];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_quo   = {r_q[NS][2], r_q[NS][1], r_q[NS][0]};
    assign o_flags = r_fl[NS];
endmodule

// File: sv/vector3_normalize.sv
// Vector normalizer: a fully pipelined unit that takes one signed 3D vector per beat and
// returns it scaled to unit length in Q1.15, saturated to +-32767, with a flag and zero
// outputs for a zero vector. One vector is accepted every cycle while the output is not
// stalled; the pipeline runs through the squaring and summing stages, the digit-per-stage
// square root, the bit-per-stage divider and an output register.
// The whole pipeline holds on back-pressure, so stalls lose nothing.
module vector3_normalize #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vn_in_if.sink    i_in,
    vn_out_if.source o_out
);
    import vn_pkg::*;
    localparam int W  = COMPONENT_WIDTH;
    localparam int SW = 3*W + 4;

    logic           en;
    logic           sq_v, rt_v, dv_v;
    logic [3*W-1:0] sq_mag;
    logic [2:0]     sq_neg;
    logic [2*W-1:0] sq_sum;
    logic [W+7:0]   rt_root;
    logic [SW-1:0]  rt_side;
    logic [47:0]    dv_quo;
    logic [3:0]     dv_fl;
    logic [47:0]    n_unit;

    logic           r_valid;
    logic [47:0]    r_unit;
    logic           r_zero;

    assign en         = !r_valid || o_out.ready;
    assign i_in.ready = en;

    vn_sq #(.W(W)) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_comp  ({i_in.z_in, i_in.y_in, i_in.x_in}),
        .o_valid (sq_v),
        .o_mag   (sq_mag),
        .o_neg   (sq_neg),
        .o_sum   (sq_sum)
    );

    vn_sqrt #(.W(W), .SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_sum   (sq_sum),
        .i_side  ({sq_sum == '0, sq_neg, sq_mag}),
        .o_valid (rt_v),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    vn_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_v),
        .i_len   (rt_root),
        .i_mag   (rt_side[3*W-1:0]),
        .i_flags (rt_side[SW-1:3*W]),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_flags (dv_fl)
    );

    // quotient tops out at 32768 on an axis-aligned vector
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic [15:0] sat;
            sat = (dv_quo[j*16 +: 16] > 16'(VN_UNIT_MAX)) ? 16'(VN_UNIT_MAX)
                                                          : dv_quo[j*16 +: 16];
            if (dv_fl[3]) begin
                n_unit[j*16 +: 16] = '0;
            end else if (dv_fl[j]) begin
                n_unit[j*16 +: 16] = (~sat) + 16'd1;
            end else begin
                n_unit[j*16 +: 16] = sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_unit <= n_unit;
            r_zero <= dv_fl[3];
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.x_unit      = r_unit[15:0];
    assign o_out.y_unit      = r_unit[31:16];
    assign o_out.z_unit      = r_unit[47:32];
    assign o_out.zero_vector = r_zero;
endmodule
